@@ hw/rtl/assert_macros.svh @@
// Assertion helpers, used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/wwss_pkg.sv @@
`default_nettype none

package wwss_pkg;

  localparam int unsigned WORD_MAX_DEF = 8;
  localparam int unsigned WORD_BYTES   = 8;
  localparam int unsigned WORD_W       = 8 * WORD_BYTES;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [7:0]       NUL_BYTE  = 8'h00;
  localparam logic [CNT_W-1:0] CNT_SAT   = '1;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(WORD_BYTES);

  // Space , . ! : ; ? LF TAB CR.
  localparam int unsigned N_DELIMS = 10;
  localparam logic [7:0] DELIMS [N_DELIMS] = '{
    8'h20, 8'h2C, 8'h2E, 8'h21, 8'h3A, 8'h3B, 8'h3F, 8'h0A, 8'h09, 8'h0D
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_WORD  = 2'd0,
    CFG_SEARCH_LEN   = 2'd1,
    CFG_REPLACE_WORD = 2'd2,
    CFG_REPLACE_LEN  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_HELD,
    ST_REPL,
    ST_TAIL
  } seq_state_e;

  typedef struct packed {
    logic [WORD_W-1:0] search_word;
    logic [LEN_W-1:0]  search_len;
    logic [WORD_W-1:0] replace_word;
    logic [LEN_W-1:0]  replace_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last_of_run;
    logic [CNT_W-1:0] match_total;
    logic             text_done;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } out_req_t;

  typedef struct packed {
    logic             wr_en;
    logic [LEN_W-1:0] wr_idx;
    logic [7:0]       wr_byte;
    logic [LEN_W-1:0] rd_idx;
    logic [7:0]       ref_byte;
  } tok_ctl_t;

  function automatic int unsigned held_max(int unsigned word_max);
    return (word_max < WORD_BYTES) ? word_max : WORD_BYTES;
  endfunction

  function automatic logic [7:0] word_byte(logic [WORD_W-1:0] w, logic [2:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    logic hit;
    hit = (b == NUL_BYTE);
    for (int k = 0; k < N_DELIMS; k++) begin
      hit = hit | (b == DELIMS[k]);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wwss_tok_buf.sv @@
`default_nettype none

// Holds the bytes of the pending token and compares one of them per cycle
// against a byte of the search word. The read address is the walk index of the
// next cycle, so the registered byte lines up with the current index.
module wwss_tok_buf #(
  parameter int unsigned DEPTH = wwss_pkg::WORD_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire wwss_pkg::tok_ctl_t ctl_i,
  output logic [7:0]              rd_byte_o,
  output logic                    eq_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_idx[IDX_W-1:0]] <= ctl_i.wr_byte;
    end
    rd_q <= mem_q[ctl_i.rd_idx[IDX_W-1:0]];
  end

  assign rd_byte_o = rd_q;
  assign eq_o      = (rd_q == ctl_i.ref_byte);

endmodule

`default_nettype wire

@@ hw/rtl/wwss_out_reg.sv @@
`default_nettype none

// Output register: holds one result until the downstream side takes it.
module wwss_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wwss_pkg::out_req_t req_i,
  output logic                    free_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output wwss_pkg::result_t       res_o
);

  logic              valid_q, valid_d;
  wwss_pkg::result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (req_i.load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      res_q <= req_i.res;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/wwss_seq.sv @@
`default_nettype none
`include "assert_macros.svh"

// Sequencer: decides what each request causes, walks the held token through
// the byte comparator and emits the results one per cycle while the output register is free.
module wwss_seq #(
  parameter int unsigned WORD_MAX = wwss_pkg::WORD_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               in_end_i,
  output logic                    in_ready_o,
  input  wire wwss_pkg::cfg_t     cfg_i,
  output wwss_pkg::tok_ctl_t      tok_ctl_o,
  input  wire logic [7:0]         tok_rd_byte_i,
  input  wire logic               tok_eq_i,
  output wwss_pkg::out_req_t      out_req_o,
  input  wire logic               out_free_i
);

  localparam int unsigned LEN_W = wwss_pkg::LEN_W;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(wwss_pkg::held_max(WORD_MAX));
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  wwss_pkg::seq_state_e state_q, state_d;
  logic [LEN_W-1:0]           idx_q, idx_d;
  logic [LEN_W-1:0]           count_q, count_d;
  logic                       pass_q, pass_d;
  logic                       hit_q, hit_d;
  logic                       tail_q, tail_d;
  logic                       done_q, done_d;
  logic [7:0]                 byte_q, byte_d;
  logic [wwss_pkg::CNT_W-1:0] match_q, match_d;

  logic [LEN_W-1:0] slen, rlen;
  logic             accept, delim, flush_need, prefix_ok;
  logic             held_last, repl_last;
  logic             walk_st, quiet_st;

  always_comb begin
    slen = (cfg_i.search_len > LEN_CAP) ? LEN_CAP : cfg_i.search_len;
    rlen = (cfg_i.replace_len > wwss_pkg::LEN_LIMIT) ? wwss_pkg::LEN_LIMIT
                                                     : cfg_i.replace_len;
  end

  assign in_ready_o = (state_q == wwss_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign delim      = wwss_pkg::is_delim(in_byte_i);
  assign flush_need = !pass_q && (count_q != '0);
  assign prefix_ok  = (count_q < slen) &&
                      (in_byte_i == wwss_pkg::word_byte(cfg_i.search_word, count_q[2:0]));
  assign held_last  = (idx_q == count_q - LEN_ONE);
  assign repl_last  = (idx_q == rlen - LEN_ONE);

  // Next state and state registers.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    pass_d  = pass_q;
    hit_d   = hit_q;
    tail_d  = tail_q;
    done_d  = done_q;
    byte_d  = byte_q;
    match_d = match_q;
    unique case (state_q)
      wwss_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_end_i || delim) begin
            tail_d = in_end_i || (in_byte_i != wwss_pkg::NUL_BYTE);
            done_d = in_end_i;
            byte_d = in_end_i ? wwss_pkg::NUL_BYTE : in_byte_i;
            pass_d = 1'b0;
            if (flush_need) begin
              state_d = wwss_pkg::ST_CMP;
              idx_d   = '0;
              hit_d   = (count_q == slen);
            end else begin
              count_d = '0;
              state_d = (in_end_i || (in_byte_i != wwss_pkg::NUL_BYTE)) ?
                        wwss_pkg::ST_TAIL : wwss_pkg::ST_IDLE;
            end
          end else if (pass_q) begin
            tail_d  = 1'b1;
            done_d  = 1'b0;
            byte_d  = in_byte_i;
            state_d = wwss_pkg::ST_TAIL;
          end else if (prefix_ok) begin
            count_d = count_q + LEN_ONE;
          end else begin
            pass_d = 1'b1;
            tail_d = 1'b1;
            done_d = 1'b0;
            byte_d = in_byte_i;
            idx_d  = '0;
            state_d = (count_q != '0) ? wwss_pkg::ST_HELD : wwss_pkg::ST_TAIL;
          end
        end
      end
      wwss_pkg::ST_CMP: begin
        idx_d = idx_q + LEN_ONE;
        hit_d = hit_q && tok_eq_i;
        if (held_last) begin
          idx_d = '0;
          if (hit_q && tok_eq_i) begin
            count_d = '0;
            if (match_q != wwss_pkg::CNT_SAT) begin
              match_d = match_q + 1'b1;
            end
            if (rlen != '0) begin
              state_d = wwss_pkg::ST_REPL;
            end else begin
              state_d = tail_q ? wwss_pkg::ST_TAIL : wwss_pkg::ST_IDLE;
            end
          end else begin
            state_d = wwss_pkg::ST_HELD;
          end
        end
      end
      wwss_pkg::ST_HELD: begin
        if (out_free_i) begin
          idx_d = idx_q + LEN_ONE;
          if (held_last) begin
            count_d = '0;
            state_d = tail_q ? wwss_pkg::ST_TAIL : wwss_pkg::ST_IDLE;
          end
        end
      end
      wwss_pkg::ST_REPL: begin
        if (out_free_i) begin
          idx_d = idx_q + LEN_ONE;
          if (repl_last) begin
            state_d = tail_q ? wwss_pkg::ST_TAIL : wwss_pkg::ST_IDLE;
          end
        end
      end
      wwss_pkg::ST_TAIL: begin
        if (out_free_i) begin
          state_d = wwss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wwss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwss_pkg::ST_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      pass_q  <= 1'b0;
      hit_q   <= 1'b0;
      tail_q  <= 1'b0;
      done_q  <= 1'b0;
      match_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      pass_q  <= pass_d;
      hit_q   <= hit_d;
      tail_q  <= tail_d;
      done_q  <= done_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // Outputs. The token store registers its read data, so it is addressed with
  // the index of the coming cycle.
  always_comb begin
    tok_ctl_o.wr_en    = accept && !in_end_i && !delim && !pass_q && prefix_ok;
    tok_ctl_o.wr_idx   = count_q;
    tok_ctl_o.wr_byte  = in_byte_i;
    tok_ctl_o.rd_idx   = idx_d;
    tok_ctl_o.ref_byte = wwss_pkg::word_byte(cfg_i.search_word, idx_q[2:0]);

    out_req_o.load            = 1'b0;
    out_req_o.res.out_byte    = tok_rd_byte_i;
    out_req_o.res.byte_valid  = 1'b1;
    out_req_o.res.last_of_run = 1'b0;
    out_req_o.res.match_total = match_q;
    out_req_o.res.text_done   = 1'b0;
    unique case (state_q)
      wwss_pkg::ST_HELD: begin
        out_req_o.load            = out_free_i;
        out_req_o.res.last_of_run = held_last && !tail_q;
      end
      wwss_pkg::ST_REPL: begin
        out_req_o.load            = out_free_i;
        out_req_o.res.out_byte    = wwss_pkg::word_byte(cfg_i.replace_word, idx_q[2:0]);
        out_req_o.res.last_of_run = repl_last && !tail_q;
      end
      wwss_pkg::ST_TAIL: begin
        out_req_o.load            = out_free_i;
        out_req_o.res.out_byte    = byte_q;
        out_req_o.res.byte_valid  = !done_q;
        out_req_o.res.last_of_run = 1'b1;
        out_req_o.res.text_done   = done_q;
      end
      default: begin
        out_req_o.load = 1'b0;
      end
    endcase
  end

  assign walk_st  = (state_q == wwss_pkg::ST_HELD) || (state_q == wwss_pkg::ST_CMP);
  assign quiet_st = (state_q == wwss_pkg::ST_IDLE) || (state_q == wwss_pkg::ST_CMP);

  `ASSERT_AT(a_walk_in_range, clk_i, rst_ni, walk_st |-> (idx_q < count_q), "Walk past held bytes.")
  `ASSERT_AT(a_quiet_states, clk_i, rst_ni, quiet_st |-> !out_req_o.load, "Load in a quiet state.")
  `ASSERT_AT(a_pass_no_held, clk_i, rst_ni, (in_ready_o && pass_q) |-> (count_q == '0), "Held bytes.")
  `ASSERT_NEXT(a_count_rises, clk_i, rst_ni, 1'b1, match_q >= $past(match_q), "Count fell.")

endmodule

`default_nettype wire

@@ hw/rtl/whole_word_stream_substitute.sv @@
`default_nettype none

// Whole-word search and replace over a byte stream. Each request on the slave
// stream carries one text byte, or an end-of-text mark in s_tuser_i. A token is
// a run of bytes between delimiters (space , . ! : ; ? LF TAB CR, and byte
// zero, which ends a token but is never sent on). Every token that equals the
// configured search word is replaced by the replacement word and counted in a
// 16-bit match counter that saturates; all other bytes pass unchanged. Bytes
// are held back only while the token is still a prefix of the search word, so
// at most eight bytes are ever pending. An end mark flushes the pending token
// and then produces a done marker; the counter keeps its value across texts.
// A request whose byte is only held, or a byte zero with nothing pending,
// produces no result. Otherwise the block accepts the request, then, if a
// held token has to be resolved, compares its held bytes in the byte
// comparator, then emits its results while the master side is ready. A
// request produces at most nine results, all through the single output
// register. s_tready_o is high only while the sequencer is idle. The master
// side carries the results of each request with m_tlast_o on the last one.
// Configuration writes go through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// take effect at once; they must only be issued while no request is in
// progress.
module whole_word_stream_substitute #(
  parameter int unsigned WORD_MAX = wwss_pkg::WORD_MAX_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Slave stream.
  input  wire logic                            s_tvalid_i,
  output logic                                 s_tready_o,
  input  wire logic [7:0]                      s_tdata_i,   // [7:0] text_byte
  input  wire logic                            s_tuser_i,   // [0] end_flag
  // Master stream.
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  output logic [23:0]                          m_tdata_o,   // [7:0] out_byte,
                                                            // [23:8] match_total
  output logic [1:0]                           m_tuser_o,   // [0] byte_valid,
                                                            // [1] text_done
  output logic                                 m_tlast_o,   // last_of_run
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [wwss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wwss_pkg::WORD_W-1:0]     cfg_wdata_i
);

  localparam int unsigned HELD_MAX = wwss_pkg::held_max(WORD_MAX);

  wwss_pkg::cfg_t     cfg_q, cfg_d;
  wwss_pkg::tok_ctl_t tok_ctl;
  wwss_pkg::out_req_t out_req;
  wwss_pkg::result_t  res;
  logic [7:0]         tok_rd_byte;
  logic               tok_eq;
  logic               out_free;

  // Configuration registers. The length registers keep the low four bits.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (wwss_pkg::cfg_reg_e'(cfg_idx_i))
        wwss_pkg::CFG_SEARCH_WORD:  cfg_d.search_word  = cfg_wdata_i;
        wwss_pkg::CFG_SEARCH_LEN:   cfg_d.search_len   = cfg_wdata_i[wwss_pkg::LEN_W-1:0];
        wwss_pkg::CFG_REPLACE_WORD: cfg_d.replace_word = cfg_wdata_i;
        wwss_pkg::CFG_REPLACE_LEN:  cfg_d.replace_len  = cfg_wdata_i[wwss_pkg::LEN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.search_word  <= '0;
      cfg_q.search_len   <= wwss_pkg::LEN_W'(1);
      cfg_q.replace_word <= '0;
      cfg_q.replace_len  <= wwss_pkg::LEN_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wwss_seq #(
    .WORD_MAX (WORD_MAX)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid_i),
    .in_byte_i     (s_tdata_i),
    .in_end_i      (s_tuser_i),
    .in_ready_o    (s_tready_o),
    .cfg_i         (cfg_q),
    .tok_ctl_o     (tok_ctl),
    .tok_rd_byte_i (tok_rd_byte),
    .tok_eq_i      (tok_eq),
    .out_req_o     (out_req),
    .out_free_i    (out_free)
  );

  wwss_tok_buf #(
    .DEPTH (HELD_MAX)
  ) u_tok_buf (
    .clk_i     (clk_i),
    .ctl_i     (tok_ctl),
    .rd_byte_o (tok_rd_byte),
    .eq_o      (tok_eq)
  );

  wwss_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (out_req),
    .free_o  (out_free),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .res_o   (res)
  );

  assign m_tdata_o = {res.match_total, res.out_byte};
  assign m_tuser_o = {res.text_done, res.byte_valid};
  assign m_tlast_o = res.last_of_run;

endmodule

`default_nettype wire
